// ===== design/assert_macros.svh =====
// Assertion macros shared by the vertex normal accumulator design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/vna_pkg.sv =====
// Package with shared types and codes of the vertex normal accumulator.
`timescale 1ns / 1ps
package vna_pkg;
  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpTri = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;
  localparam logic [1:0] OpUnknown = 2'd3;
  localparam logic KindTri = 1'b0;
  localparam logic KindVertex = 1'b1;
  localparam int VecW = 64;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] idx;
    logic [15:0] ka;
    logic [15:0] kb;
    logic [15:0] kc;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [VecW-1:0] vz;
  } nreq_t;
endpackage

// ===== design/vna_front.sv =====
// Front end: accepts transactions, drops unknown codes and queues commands.
`timescale 1ns / 1ps
module vna_front #(
  parameter int IdxW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          operation_i,
  input  logic [IdxW-1:0]     vertex_index_i,
  input  logic [15:0]         pos_x_i,
  input  logic [15:0]         pos_y_i,
  input  logic [15:0]         pos_z_i,
  input  logic [IdxW-1:0]     corner_a_i,
  input  logic [IdxW-1:0]     corner_b_i,
  input  logic [IdxW-1:0]     corner_c_i,
  output logic                full_o,
  output logic                empty_o,
  output vna_pkg::cmd_t       cmd_o,
  input  logic                pop_i
);
  vna_pkg::cmd_t fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;
  vna_pkg::cmd_t c;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign push    = start_i && !full_o && operation_i != vna_pkg::OpUnknown;
  assign cmd_o   = fifo_q[rp_q];

  always_comb begin
    c = '0;
    c.op = operation_i;
    c.idx = 16'(vertex_index_i);
    c.ka = 16'(corner_a_i);
    c.kb = 16'(corner_b_i);
    c.kc = 16'(corner_c_i);
    c.px = pos_x_i;
    c.py = pos_y_i;
    c.pz = pos_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

// ===== design/vna_norm.sv =====
// Normalizer: scales a vector, takes an integer square root and divides.
`timescale 1ns / 1ps
module vna_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_i,
  input  vna_pkg::nreq_t vec_i,
  output logic          idle_o,
  output logic          valid_o,
  output logic          kind_o,
  output logic [15:0]   nx_o,
  output logic [15:0]   ny_o,
  output logic [15:0]   nz_o,
  output logic          degen_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SShift = 3'd1;
  localparam logic [2:0] SSq = 3'd2;
  localparam logic [2:0] SSqrt = 3'd3;
  localparam logic [2:0] SDiv = 3'd4;

  logic [2:0]  st_q;
  logic        kind_q;
  logic [2:0]  neg_q;
  logic [63:0] m_q [3];
  logic [29:0] u_q [3];
  logic [1:0]  ci_q;
  logic [62:0] s_q;
  logic [31:0] res_q;
  logic [4:0]  it_q;
  logic [47:0] rem_q;
  logic [45:0] num_q;
  logic [5:0]  dc_q;
  logic [45:0] quo_q;
  logic [15:0] out_q [3];
  logic        valid_q;
  logic        degen_q;

  logic [63:0] mx;
  logic [6:0]  bl;
  logic [6:0]  sh;
  logic [47:0] rtry;
  logic [15:0] q16;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    bl = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (mx[i]) bl = 7'(i + 1);
    end
    sh = bl > 7'd30 ? bl - 7'd30 : 7'd0;
    rtry = {rem_q[46:0], num_q[45]} - {16'd0, res_q};
    q16 = 16'(({quo_q[44:0], ~rtry[47]} + 46'd1) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (st_q == SShift && mx == 64'd0) ||
                 (st_q == SDiv && dc_q == 6'd0 && ci_q == 2'd2);
      case (st_q)
        SIdle: begin
          if (req_i) begin
            kind_q <= vec_i.kind;
            neg_q <= {vec_i.vz[63], vec_i.vy[63], vec_i.vx[63]};
            m_q[0] <= mag(vec_i.vx);
            m_q[1] <= mag(vec_i.vy);
            m_q[2] <= mag(vec_i.vz);
            st_q <= SShift;
          end
        end
        SShift: begin
          if (mx == 64'd0) begin
            out_q[0] <= '0;
            out_q[1] <= '0;
            out_q[2] <= '0;
            degen_q <= 1'b1;
            st_q <= SIdle;
          end else begin
            for (int i = 0; i < 3; i++) u_q[i] <= 30'(m_q[i] >> sh);
            s_q <= '0;
            ci_q <= 2'd0;
            st_q <= SSq;
          end
        end
        SSq: begin
          s_q <= s_q + 63'(60'(u_q[ci_q]) * 60'(u_q[ci_q]));
          if (ci_q == 2'd2) begin
            res_q <= '0;
            it_q <= 5'd31;
            st_q <= SSqrt;
          end else begin
            ci_q <= ci_q + 2'd1;
          end
        end
        SSqrt: begin
          // One result bit per cycle, from the top: set it if the square fits.
          if (64'(res_q | (32'd1 << it_q)) * 64'(res_q | (32'd1 << it_q)) <= 64'(s_q)) begin
            res_q <= res_q | (32'd1 << it_q);
          end
          if (it_q == 5'd0) begin
            ci_q <= 2'd0;
            rem_q <= '0;
            num_q <= {1'b0, u_q[0], 15'd0};
            quo_q <= '0;
            dc_q <= 6'd45;
            degen_q <= 1'b0;
            st_q <= SDiv;
          end else begin
            it_q <= it_q - 5'd1;
          end
        end
        SDiv: begin
          if (dc_q == 6'd0) begin
            out_q[ci_q] <= neg_q[ci_q] ? 16'(-q16) : q16;
            if (ci_q == 2'd2) begin
              st_q <= SIdle;
            end else begin
              ci_q <= ci_q + 2'd1;
              rem_q <= '0;
              num_q <= {1'b0, u_q[ci_q + 2'd1], 15'd0};
              quo_q <= '0;
              dc_q <= 6'd45;
            end
          end else begin
            if (rtry[47]) begin
              rem_q <= {rem_q[46:0], num_q[45]};
            end else begin
              rem_q <= rtry;
            end
            num_q <= {num_q[44:0], 1'b0};
            quo_q <= {quo_q[44:0], ~rtry[47]};
            dc_q <= dc_q - 6'd1;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign idle_o  = st_q == SIdle && !valid_q;
  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign nx_o    = out_q[0];
  assign ny_o    = out_q[1];
  assign nz_o    = out_q[2];
  assign degen_o = degen_q;
endmodule

// ===== design/vna_back.sv =====
// Back end: vertex and sum memories, cross product and accumulation.
`timescale 1ns / 1ps
module vna_back #(
  parameter int VertexCount = 1024,
  parameter int SumWidth = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  vna_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  output logic           nreq_o,
  output vna_pkg::nreq_t nvec_o,
  input  logic           nidle_i,
  output logic           idle_o
);
  localparam int AW = $clog2(VertexCount);
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SRdA = 4'd1;
  localparam logic [3:0] SRdB = 4'd2;
  localparam logic [3:0] SRdC = 4'd3;
  localparam logic [3:0] SEdge = 4'd4;
  localparam logic [3:0] SMul = 4'd5;
  localparam logic [3:0] SAccR = 4'd6;
  localparam logic [3:0] SAccW = 4'd7;
  localparam logic [3:0] SRdS = 4'd8;
  localparam logic [3:0] SSend = 4'd9;
  localparam logic [3:0] SWaitN = 4'd10;
  localparam logic [3:0] SAccD = 4'd11;

  logic [47:0]         pos_mem [VertexCount];
  logic [3*SumWidth-1:0] sum_mem [VertexCount];
  logic [47:0]         pos_rd_q;
  logic [3*SumWidth-1:0] sum_rd_q;

  logic [3:0]  st_q;
  logic        kind_q;
  logic [AW-1:0] ka_q, kb_q, kc_q, raddr, waddr;
  logic        we;
  logic [3*SumWidth-1:0] wdata;
  logic [47:0] pa_q, pb_q;
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [34:0] p_q [6];
  logic signed [35:0] cr_q [3];
  logic [1:0]  corner_q;
  logic signed [63:0] v_q [3];

  function automatic logic signed [16:0] sx(input logic [47:0] w, input int k);
    sx = 17'(signed'(w[16*k +: 16]));
  endfunction

  function automatic logic [SumWidth-1:0] sat(input logic [SumWidth-1:0] a,
                                              input logic signed [35:0] b);
    logic signed [SumWidth:0] r;
    logic signed [SumWidth:0] hi;
    logic signed [SumWidth:0] lo;
    r = (SumWidth+1)'(signed'(a)) + (SumWidth+1)'(b);
    hi = (SumWidth+1)'({1'b0, {(SumWidth-1){1'b1}}});
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    sat = r[SumWidth-1:0];
  endfunction

  always_comb begin
    raddr = AW'(cmd_i.idx);
    case (st_q)
      SIdle: raddr = cmd_i.op == vna_pkg::OpTri ? AW'(cmd_i.ka) : AW'(cmd_i.idx);
      SRdA: raddr = kb_q;
      SRdB: raddr = kc_q;
      SMul: raddr = ka_q;
      SAccR: raddr = corner_q == 2'd0 ? ka_q : (corner_q == 2'd1 ? kb_q : kc_q);
      default: raddr = ka_q;
    endcase
    we = 1'b0;
    waddr = AW'(cmd_i.idx);
    wdata = '0;
    if (st_q == SIdle && !empty_i && cmd_i.op == vna_pkg::OpLoad) we = 1'b1;
    if (st_q == SAccW) begin
      we = 1'b1;
      waddr = corner_q == 2'd0 ? ka_q : (corner_q == 2'd1 ? kb_q : kc_q);
      for (int i = 0; i < 3; i++) begin
        wdata[SumWidth*i +: SumWidth] = sat(sum_rd_q[SumWidth*i +: SumWidth], cr_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[raddr];
    sum_rd_q <= sum_mem[raddr];
    if (st_q == SIdle && !empty_i && cmd_i.op == vna_pkg::OpLoad) begin
      pos_mem[waddr] <= {cmd_i.pz, cmd_i.py, cmd_i.px};
    end
    if (we) sum_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      case (st_q)
        SIdle: begin
          if (!empty_i) begin
            ka_q <= AW'(cmd_i.op == vna_pkg::OpRead ? cmd_i.idx : cmd_i.ka);
            kb_q <= AW'(cmd_i.kb);
            kc_q <= AW'(cmd_i.kc);
            case (cmd_i.op)
              vna_pkg::OpTri: st_q <= SRdA;
              vna_pkg::OpRead: st_q <= SRdS;
              default: st_q <= SIdle;
            endcase
          end
        end
        SRdA: st_q <= SRdB;
        SRdB: begin
          pa_q <= pos_rd_q;
          st_q <= SRdC;
        end
        SRdC: begin
          pb_q <= pos_rd_q;
          st_q <= SEdge;
        end
        SEdge: begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= sx(pb_q, i) - sx(pa_q, i);
            e2_q[i] <= sx(pos_rd_q, i) - sx(pa_q, i);
          end
          st_q <= SMul;
        end
        SMul: begin
          p_q[0] <= 35'(e1_q[1] * e2_q[2]);
          p_q[1] <= 35'(e1_q[2] * e2_q[1]);
          p_q[2] <= 35'(e1_q[2] * e2_q[0]);
          p_q[3] <= 35'(e1_q[0] * e2_q[2]);
          p_q[4] <= 35'(e1_q[0] * e2_q[1]);
          p_q[5] <= 35'(e1_q[1] * e2_q[0]);
          corner_q <= 2'd0;
          st_q <= SAccD;
        end
        SAccD: begin
          for (int i = 0; i < 3; i++) begin
            cr_q[i] <= 36'(p_q[2*i]) - 36'(p_q[2*i+1]);
          end
          st_q <= SAccR;
        end
        SAccR: st_q <= SAccW;
        SAccW: begin
          if (corner_q == 2'd2) begin
            kind_q <= vna_pkg::KindTri;
            for (int i = 0; i < 3; i++) v_q[i] <= 64'(cr_q[i]);
            st_q <= SWaitN;
          end else begin
            corner_q <= corner_q + 2'd1;
            st_q <= SAccR;
          end
        end
        SRdS: st_q <= SSend;
        SSend: begin
          kind_q <= vna_pkg::KindVertex;
          for (int i = 0; i < 3; i++) begin
            v_q[i] <= 64'(signed'(sum_rd_q[SumWidth*i +: SumWidth]));
          end
          st_q <= SWaitN;
        end
        SWaitN: begin
          if (nidle_i) st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign pop_o = st_q == SIdle && !empty_i;
  assign nreq_o = st_q == SWaitN && nidle_i;
  assign nvec_o = '{kind: kind_q, vx: v_q[0], vy: v_q[1], vz: v_q[2]};
  assign idle_o = st_q == SIdle;
endmodule

// ===== design/vertex_normal_accumulator.sv =====
// Top level of the vertex normal accumulator.
// Usage: drive operation_i and its fields with start; the transaction is
// taken at a rising edge where start is high and busy is low.
// A load stores a position and clears that vertex's sum and gives no result.
// A triangle adds its cross product to its three corners' sums and gives its
// unit normal; a read gives the unit normal of one vertex's sum.
// Each result shows for one cycle with done_o high; it cannot be stalled.
// A two-entry command queue parts the front from the memory back end, and
// the back end hands each vector to an iterative normalizer; busy is high
// while the queue is full.
// The normalizer works in steps: one scaling step, three squaring steps,
// 32 square root steps and three 46-step dividers. It takes no new vector
// until the result of the last one is out, and the back end waits for that.
// Loads are written in the back end's idle state.
// Code 3 is dropped with no result.
// Reset clears control only; memories are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = 1024,
  parameter int SUM_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  vertex_index_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [9:0]  corner_a_i,
  input  logic [9:0]  corner_b_i,
  input  logic [9:0]  corner_c_i,
  output logic        done_o,
  output logic        result_kind_o,
  output logic [15:0] norm_x_o,
  output logic [15:0] norm_y_o,
  output logic [15:0] norm_z_o,
  output logic        degenerate_o
);
  logic full, empty, pop, nreq, nidle, bidle;
  vna_pkg::cmd_t  cmd;
  vna_pkg::nreq_t nvec;

  vna_front #(.IdxW(10)) u_front (
    .clk_i, .rst_ni, .start_i(start), .operation_i, .vertex_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .corner_a_i, .corner_b_i, .corner_c_i,
    .full_o(full), .empty_o(empty), .cmd_o(cmd), .pop_i(pop)
  );

  vna_back #(.VertexCount(VERTEX_COUNT), .SumWidth(SUM_WIDTH)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd), .pop_o(pop),
    .nreq_o(nreq), .nvec_o(nvec), .nidle_i(nidle), .idle_o(bidle)
  );

  vna_norm u_norm (
    .clk_i, .rst_ni, .req_i(nreq), .vec_i(nvec), .idle_o(nidle),
    .valid_o(done_o), .kind_o(result_kind_o), .nx_o(norm_x_o), .ny_o(norm_y_o),
    .nz_o(norm_z_o), .degen_o(degenerate_o)
  );

  assign busy = full;

  `ASSERT_IMPL(a_pop_nonempty, pop, !empty, "pop from empty queue")
  `ASSERT_IMPL(a_req_idle, nreq, nidle, "normalizer request while busy")
  `ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result held more than one cycle")
  `ASSERT_IMPL(a_pop_back_idle, pop, bidle, "back end popped while busy")
endmodule

// ===== sim/tb_vertex_normal_accumulator.sv =====
// Testbench of the vertex normal accumulator with a predicting scoreboard.
`timescale 1ns / 1ps
module tb_vertex_normal_accumulator;

  typedef struct {
    logic        kind;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  class normal_scoreboard;
    logic [15:0] px[1024];
    logic [15:0] py[1024];
    logic [15:0] pz[1024];
    longint      sx[1024];
    longint      sy[1024];
    longint      sz[1024];
    normal_t     pending_normals[$];
    int          errors;
    int          results_seen;

    function longint sat_sum(longint a, longint b);
      longint hi;
      longint r;
      hi = (64'sd1 <<< 47) - 1;
      r = a + b;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > s) bt = bt >> 2;
      while (bt != 0) begin
        if (s >= res + bt) begin
          s = s - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function normal_t unit_normal(logic kind, longint v[3]);
      normal_t n;
      longint unsigned m[3];
      longint unsigned mx;
      longint unsigned s2;
      longint unsigned len;
      longint unsigned q;
      longint r[3];
      int bits;
      int sh;
      n.kind = kind;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        n.nx = '0;
        n.ny = '0;
        n.nz = '0;
        n.degen = 1'b1;
        return n;
      end
      bits = 0;
      while (bits < 64 && (mx >> bits) != 0) bits++;
      sh = (bits > 30) ? bits - 30 : 0;
      s2 = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = m[i] >> sh;
        s2 = s2 + m[i] * m[i];
      end
      len = int_sqrt(s2);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 32768 / len + 1) >> 1;
        r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      n.nx = r[0][15:0];
      n.ny = r[1][15:0];
      n.nz = r[2][15:0];
      n.degen = 1'b0;
      return n;
    endfunction

    function void note_command(logic [1:0] op, logic [9:0] idx, logic [15:0] x,
                               logic [15:0] y, logic [15:0] z, logic [9:0] ca,
                               logic [9:0] cb, logic [9:0] cc);
      longint e1[3];
      longint e2[3];
      longint cr[3];
      longint v[3];
      if (op == vna_pkg::OpLoad) begin
        px[idx] = x;
        py[idx] = y;
        pz[idx] = z;
        sx[idx] = 0;
        sy[idx] = 0;
        sz[idx] = 0;
      end else if (op == vna_pkg::OpTri) begin
        e1[0] = longint'($signed(px[cb])) - longint'($signed(px[ca]));
        e1[1] = longint'($signed(py[cb])) - longint'($signed(py[ca]));
        e1[2] = longint'($signed(pz[cb])) - longint'($signed(pz[ca]));
        e2[0] = longint'($signed(px[cc])) - longint'($signed(px[ca]));
        e2[1] = longint'($signed(py[cc])) - longint'($signed(py[ca]));
        e2[2] = longint'($signed(pz[cc])) - longint'($signed(pz[ca]));
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sx[ca] = sat_sum(sx[ca], cr[0]);
        sy[ca] = sat_sum(sy[ca], cr[1]);
        sz[ca] = sat_sum(sz[ca], cr[2]);
        sx[cb] = sat_sum(sx[cb], cr[0]);
        sy[cb] = sat_sum(sy[cb], cr[1]);
        sz[cb] = sat_sum(sz[cb], cr[2]);
        sx[cc] = sat_sum(sx[cc], cr[0]);
        sy[cc] = sat_sum(sy[cc], cr[1]);
        sz[cc] = sat_sum(sz[cc], cr[2]);
        pending_normals.push_back(unit_normal(vna_pkg::KindTri, cr));
      end else if (op == vna_pkg::OpRead) begin
        v[0] = sx[idx];
        v[1] = sy[idx];
        v[2] = sz[idx];
        pending_normals.push_back(unit_normal(vna_pkg::KindVertex, v));
      end
    endfunction

    function void check_result(logic kind, logic [15:0] nx, logic [15:0] ny,
                               logic [15:0] nz, logic degen);
      normal_t e;
      results_seen++;
      if (pending_normals.size() == 0) begin
        $error("unexpected result: kind %0d norm %h %h %h", kind, nx, ny, nz);
        errors++;
        return;
      end
      e = pending_normals.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (nx !== e.nx) begin
        $error("norm_x expected %h actual %h", e.nx, nx);
        errors++;
      end
      if (ny !== e.ny) begin
        $error("norm_y expected %h actual %h", e.ny, ny);
        errors++;
      end
      if (nz !== e.nz) begin
        $error("norm_z expected %h actual %h", e.nz, nz);
        errors++;
      end
      if (degen !== e.degen) begin
        $error("degenerate expected %0d actual %0d", e.degen, degen);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = vna_pkg::OpLoad;
  logic [9:0]  vertex_index_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] pos_z_i = '0;
  logic [9:0]  corner_a_i = '0;
  logic [9:0]  corner_b_i = '0;
  logic [9:0]  corner_c_i = '0;
  logic        done_o;
  logic        result_kind_o;
  logic [15:0] norm_x_o;
  logic [15:0] norm_y_o;
  logic [15:0] norm_z_o;
  logic        degenerate_o;

  normal_scoreboard sb = new();
  bit   loaded[1024];
  int   loaded_list[$];
  int   sent_count;
  int   cycle_count;
  int   idle_pct;

  vertex_normal_accumulator dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 1500000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(result_kind_o, norm_x_o, norm_y_o, norm_z_o, degenerate_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(logic [1:0] op, logic [9:0] idx, logic [15:0] x, logic [15:0] y,
                      logic [15:0] z, logic [9:0] ca, logic [9:0] cb, logic [9:0] cc);
    operation_i = op;
    vertex_index_i = idx;
    pos_x_i = x;
    pos_y_i = y;
    pos_z_i = z;
    corner_a_i = ca;
    corner_b_i = cb;
    corner_c_i = cc;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_command(op, idx, x, y, z, ca, cb, cc);
    sent_count++;
    if (op == vna_pkg::OpLoad && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    start = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending_normals.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  function automatic logic [9:0] any_loaded();
    return 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic random_transaction();
    int r;
    logic [9:0] idx;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    r = $urandom_range(99);
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      x = 16'($signed(x) >>> 8);
      y = 16'($signed(y) >>> 8);
    end
    if (r < 20) begin
      idx = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(31));
      send(vna_pkg::OpLoad, idx, x, y, z, 10'($urandom), 10'($urandom), 10'($urandom));
    end else if (r < 62) begin
      send(vna_pkg::OpTri, 10'($urandom), x, y, z, any_loaded(), any_loaded(),
           any_loaded());
    end else if (r < 92) begin
      send(vna_pkg::OpRead, any_loaded(), x, y, z, 10'($urandom), 10'($urandom),
           10'($urandom));
    end else begin
      send(vna_pkg::OpUnknown, 10'($urandom), x, y, z, 10'($urandom), 10'($urandom),
           10'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Extreme positions, index extremes, collinear and repeated corners.
    send(vna_pkg::OpLoad, 10'd0, 16'h7fff, 16'h8000, 16'h0000, '0, '0, '0);
    send(vna_pkg::OpLoad, 10'd1023, 16'h8000, 16'h7fff, 16'h7fff, 10'h3ff, 10'h3ff,
         10'h3ff);
    send(vna_pkg::OpLoad, 10'd2, 16'h8000, 16'h8000, 16'h8000, '0, '0, '0);
    send(vna_pkg::OpLoad, 10'd3, 16'h0100, 16'h0100, 16'h0100, '0, '0, '0);
    send(vna_pkg::OpLoad, 10'd4, 16'h0200, 16'h0200, 16'h0200, '0, '0, '0);
    send(vna_pkg::OpLoad, 10'd5, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0);
    send(vna_pkg::OpRead, 10'd5, '0, '0, '0, '0, '0, '0);
    send(vna_pkg::OpTri, '0, '0, '0, '0, 10'd0, 10'd1023, 10'd2);
    send(vna_pkg::OpTri, '0, '0, '0, '0, 10'd5, 10'd3, 10'd4);
    send(vna_pkg::OpTri, '0, '0, '0, '0, 10'd0, 10'd0, 10'd1023);
    send(vna_pkg::OpTri, '0, '0, '0, '0, 10'd2, 10'd1023, 10'd0);
    send(vna_pkg::OpTri, '0, '0, '0, '0, 10'd1023, 10'd2, 10'd2);
    send(vna_pkg::OpRead, 10'd0, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff, 10'h3ff);
    send(vna_pkg::OpRead, 10'd1023, '0, '0, '0, '0, '0, '0);
    send(vna_pkg::OpRead, 10'd2, '0, '0, '0, '0, '0, '0);
    send(vna_pkg::OpRead, 10'd3, '0, '0, '0, '0, '0, '0);
    send(vna_pkg::OpUnknown, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff,
         10'h3ff);
    send(vna_pkg::OpLoad, 10'd0, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0);
    send(vna_pkg::OpRead, 10'd0, '0, '0, '0, '0, '0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 8;
      endcase
      repeat (335) begin
        random_transaction();
        if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 40));
      end
      drain();
    end

    $display("Sent %0d transactions (loads, triangles, reads, unknown codes) and checked %0d normals.",
             sent_count, sb.results_seen);
    $display("Covered four idling phases with the sender waiting for all results between them.");
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
